// ----- rtl/box_blur_3x3_reflect_top_defines.svh -----
// Assertion macros for the box blur checker file.
`ifndef BOX_BLUR_3X3_REFLECT_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_REFLECT_TOP_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define BB3R_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bb3r check failed");

// Next-cycle implication, held off while reset is low.
`define BB3R_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bb3r check failed");

`endif

// ----- rtl/bb3r_pkg.sv -----
// Types, constants and helpers for the 3x3 reflecting box blur.
package bb3r_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int OUT_COL_W = 10;
    localparam int SUM_W     = 12;

    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(1024);
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(4096);
    localparam logic [CFG_H_W-1:0] HEIGHT_MAX   = CFG_H_W'(4096);

    // ceil(2^16 / 9); exact floor division for sums up to 9 * 255
    localparam logic [12:0] RECIP9 = 13'd7282;

    localparam int MAX_RES = 4;
    localparam int NRES_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = CFG_IDX_W'(0),
        REG_IMAGE_HEIGHT = CFG_IDX_W'(1)
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0]     blurred;
        logic [ROW_W-1:0]     out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 run_end;
        logic                 image_end;
    } res_t;

    // Position flags of an item, worked out when it is accepted
    typedef struct packed {
        logic c_ge1;
        logic c_is1;
        logic last_col;
        logic r_ge1;
        logic r_is1;
        logic last_row;
    } pos_t;

    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [24:0] prod;
        prod = 25'(s) * 25'(RECIP9);
        return prod[23:16];
    endfunction

endpackage

// ----- rtl/bb3r_if.sv -----
// Valid/ready channel interfaces for pixels in and blurred results out.
interface bb3r_pix_if import bb3r_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bb3r_res_if import bb3r_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     blurred;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 run_end;
    logic                 image_end;

    modport source (output valid, output blurred, output out_row, output out_col,
                    output run_end, output image_end, input ready);
    modport sink   (input valid, input blurred, input out_row, input out_col,
                    input run_end, input image_end, output ready);
endinterface

// ----- rtl/bb3r_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port.
module bb3r_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/bb3r_window.sv -----
// Column window registers, nine-pixel sums, divide by nine and result packing.
module bb3r_window import bb3r_pkg::*; #(
    parameter int COL_AW = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [PIX_W-1:0]  pixel,
    input  logic [COL_AW-1:0] col,
    input  logic [ROW_W-1:0]  row,
    input  pos_t              pos,
    input  logic [PIX_W-1:0]  older,
    input  logic [PIX_W-1:0]  newer,
    output res_t              res [MAX_RES],
    output logic [NRES_W-1:0] n
);

    localparam int CS_W = 10;

    logic [PIX_W-1:0] wc_reg [6];

    logic [PIX_W-1:0]  top, mid, bot;
    logic [CS_W-1:0]   cur_up, cur_dn, prv_up, prv_dn, lft_up, lft_dn;
    logic [SUM_W-1:0]  s0, s1, s2, s3;
    logic [ROW_W-1:0]  row_up;
    logic [COL_AW-1:0] col_l;
    logic              emit_any;
    res_t              k0, k1, k2, k3;

    always_comb
    begin
        // row 1 mirrors row -1 onto row 1, i.e. the incoming pixel
        top = pos.r_is1 ? pixel : older;
        mid = newer;
        bot = pixel;

        cur_up = CS_W'(top) + CS_W'(mid) + CS_W'(bot);
        cur_dn = (CS_W'(mid) << 1) + CS_W'(bot);
        prv_up = CS_W'(wc_reg[0]) + CS_W'(wc_reg[1]) + CS_W'(wc_reg[2]);
        prv_dn = (CS_W'(wc_reg[1]) << 1) + CS_W'(wc_reg[2]);
        if (pos.c_is1)
        begin
            lft_up = cur_up;
            lft_dn = cur_dn;
        end
        else
        begin
            lft_up = CS_W'(wc_reg[3]) + CS_W'(wc_reg[4]) + CS_W'(wc_reg[5]);
            lft_dn = (CS_W'(wc_reg[4]) << 1) + CS_W'(wc_reg[5]);
        end

        s0 = SUM_W'(lft_up) + SUM_W'(prv_up) + SUM_W'(cur_up);
        s1 = (SUM_W'(prv_up) << 1) + SUM_W'(cur_up);
        s2 = SUM_W'(lft_dn) + SUM_W'(prv_dn) + SUM_W'(cur_dn);
        s3 = (SUM_W'(prv_dn) << 1) + SUM_W'(cur_dn);

        row_up = row - ROW_W'(1);
        col_l  = col - COL_AW'(1);

        k0 = '{div9(s0), row_up, OUT_COL_W'(col_l), 1'b0, 1'b0};
        k1 = '{div9(s1), row_up, OUT_COL_W'(col),   1'b0, 1'b0};
        k2 = '{div9(s2), row,    OUT_COL_W'(col_l), 1'b0, 1'b0};
        k3 = '{div9(s3), row,    OUT_COL_W'(col),   1'b0, 1'b1};

        emit_any = pos.r_ge1 && pos.c_ge1;
        if (emit_any)
        begin
            n = NRES_W'(1) + NRES_W'(pos.last_col) + NRES_W'(pos.last_row)
                + NRES_W'(pos.last_col && pos.last_row);
        end
        else
        begin
            n = '0;
        end

        // packed order: upper row first, then lower row on the final row
        res[0] = k0;
        res[1] = pos.last_col ? k1 : k2;
        res[2] = k2;
        res[3] = k3;
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (n != '0 && NRES_W'(i) == n - NRES_W'(1))
            begin
                res[i].run_end = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                wc_reg[i] <= '0;
            end
        end
        else if (go)
        begin
            wc_reg[3] <= wc_reg[0];
            wc_reg[4] <= wc_reg[1];
            wc_reg[5] <= wc_reg[2];
            wc_reg[0] <= top;
            wc_reg[1] <= mid;
            wc_reg[2] <= bot;
        end
    end

endmodule

// ----- rtl/bb3r_outq.sv -----
// Shifting result queue; takes up to four results at once, hands out one per cycle while the output is ready.
module bb3r_outq import bb3r_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [NRES_W-1:0] n,
    input  res_t              in_res [MAX_RES],
    input  logic              pop,
    output res_t              head,
    output logic              head_valid,
    output logic              can_load
);

    localparam int QD = MAX_RES + 1;

    res_t              q_reg  [QD];
    res_t              q_next [QD];
    logic [NRES_W-1:0] cnt_reg, cnt_next;
    logic [NRES_W-1:0] base;
    logic [NRES_W-1:0] off;

    always_comb
    begin
        base = cnt_reg - NRES_W'(pop);
        off  = '0;
        for (int i = 0; i < QD; i++)
        begin
            if (pop && i + 1 < QD)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            off = NRES_W'(i) - base;
            if (load && NRES_W'(i) >= base && off < n)
            begin
                q_next[i] = in_res[off[1:0]];
            end
        end
        cnt_next = cnt_reg - NRES_W'(pop) + (load ? n : NRES_W'(0));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QD; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign head       = q_reg[0];
    assign head_valid = (cnt_reg != '0);
    assign can_load   = (cnt_reg <= NRES_W'(1));

endmodule

// ----- rtl/box_blur_3x3_reflect_top.sv -----
// Top level of the streaming 3x3 box blur with mirrored borders.
//
//  channel   | dir | handshake          | carries
//  ----------+-----+--------------------+-----------------------------------------
//  pixels    | in  | valid/ready        | pixel
//  results   | out | valid/ready        | blurred, out_row, out_col, run_end,
//            |     |                    | image_end
//  cfg       | in  | cfg_write, no wait | cfg_index, cfg_data
//
//  One pixel per cycle while the result queue has room. An item with more than one
//  result holds the input at the result queue until at most one is left: two on row
//  ends and on the final row, four at the image end. Results pass line RAM, then queue.
//  The line RAM needs no clearing after reset; unwritten entries are never used.
//  A stalled output holds the queue; the input keeps taking items while it has room.
module box_blur_3x3_reflect_top import bb3r_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bb3r_pix_if.sink              pixels,
    bb3r_res_if.source            results,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = (CW + 1 > CFG_W_W) ? CW + 1 : CFG_W_W;

    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic               cfg_hit;

    logic [EW-1:0]      width_ext, eff_w;
    logic [CFG_H_W-1:0] eff_h;
    logic [CW-1:0]      last_col;
    logic [ROW_W-1:0]   last_row;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    pos_t             s1_pos_reg, pos_now;

    logic pix_acc, s1_go, can_load, res_pop, head_valid;

    logic [2*PIX_W-1:0] line_rd, line_wr;
    res_t               win_res [MAX_RES];
    logic [NRES_W-1:0]  win_n;
    res_t               head;

    // configuration registers
    assign cfg_hit = cfg_write && (cfg_index == REG_IMAGE_WIDTH ||
                                   cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[CFG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[CFG_H_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        width_ext = EW'(width_reg);
        if (width_ext < EW'(2))
        begin
            eff_w = EW'(2);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_ext;
        end

        if (height_reg < CFG_H_W'(2))
        begin
            eff_h = CFG_H_W'(2);
        end
        else if (height_reg > HEIGHT_MAX)
        begin
            eff_h = HEIGHT_MAX;
        end
        else
        begin
            eff_h = height_reg;
        end

        last_col = CW'(eff_w - EW'(1));
        last_row = ROW_W'(eff_h - CFG_H_W'(1));
    end

    // accept stage: raster position and line RAM read
    assign s1_go         = s1_valid_reg && can_load;
    assign pixels.ready  = !s1_valid_reg || s1_go;
    assign pix_acc       = pixels.valid && pixels.ready;

    always_comb
    begin
        pos_now.c_ge1    = (col_reg != '0);
        pos_now.c_is1    = (col_reg == CW'(1));
        pos_now.last_col = (col_reg == last_col);
        pos_now.r_ge1    = (row_reg != '0);
        pos_now.r_is1    = (row_reg == ROW_W'(1));
        pos_now.last_row = (row_reg == last_row);

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (pix_acc)
        begin
            if (pos_now.last_col)
            begin
                col_next = '0;
                row_next = pos_now.last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end

        if (pix_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_pixel_reg <= pixels.pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_pos_reg   <= pos_now;
        end
    end

    // one entry per column: older row in the upper byte, newer row in the lower.
    // Read at accept, written back one stage later to the same column.
    assign line_wr = {line_rd[PIX_W-1:0], s1_pixel_reg};

    bb3r_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (line_wr),
        .re    (pix_acc),
        .raddr (col_reg),
        .rdata (line_rd)
    );

    bb3r_window #(
        .COL_AW (CW)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (s1_go),
        .pixel (s1_pixel_reg),
        .col   (s1_col_reg),
        .row   (s1_row_reg),
        .pos   (s1_pos_reg),
        .older (line_rd[2*PIX_W-1:PIX_W]),
        .newer (line_rd[PIX_W-1:0]),
        .res   (win_res),
        .n     (win_n)
    );

    assign res_pop = results.valid && results.ready;

    bb3r_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_go),
        .n          (win_n),
        .in_res     (win_res),
        .pop        (res_pop),
        .head       (head),
        .head_valid (head_valid),
        .can_load   (can_load)
    );

    assign results.valid     = head_valid;
    assign results.blurred   = head.blurred;
    assign results.out_row   = head.out_row;
    assign results.out_col   = head.out_col;
    assign results.run_end   = head.run_end;
    assign results.image_end = head.image_end;

endmodule

// ----- rtl/bb3r_checker.sv -----
// Port-level checks on the box blur top, attached by bind.
`include "box_blur_3x3_reflect_top_defines.svh"

module bb3r_checker import bb3r_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic [PIX_W-1:0]     blurred,
    input logic [ROW_W-1:0]     out_row,
    input logic [OUT_COL_W-1:0] out_col,
    input logic                 run_end,
    input logic                 image_end
);

    // a held result stays offered and unchanged
    `BB3R_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)
    `BB3R_ASSERT_NXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(blurred) && $stable(out_row) && $stable(out_col) && $stable(run_end) && $stable(image_end))

    // the image end closes the run of its item
    `BB3R_ASSERT_IMP(a_image_end_run, clk, rst_n, res_valid && image_end, run_end)

    // all results of one item are queued together, so a run never breaks off
    `BB3R_ASSERT_NXT(a_run_unbroken, clk, rst_n, res_valid && res_ready && !run_end, res_valid)

endmodule

bind box_blur_3x3_reflect_top bb3r_checker u_bb3r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .blurred   (results.blurred),
    .out_row   (results.out_row),
    .out_col   (results.out_col),
    .run_end   (results.run_end),
    .image_end (results.image_end)
);
